>>> hdl/hspws_pkg.sv
// Package: types, register codes and constants of the heading steering block.
package hspws_pkg;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_KP_GAIN     = 3'd0,
    REG_KI_GAIN     = 3'd1,
    REG_BASE_SPEED  = 3'd2,
    REG_DEADBAND    = 3'd3,
    REG_SPEED_LIMIT = 3'd4,
    REG_DUTY_MIN    = 3'd5,
    REG_DUTY_MAX    = 3'd6,
    REG_PWM_PERIOD  = 3'd7
  } cfg_reg_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ERR,
    S_KP,
    S_STEER,
    S_SHAPE,
    S_WHEEL,
    S_DONE
  } top_state_e;

  typedef enum logic [2:0] {
    W_IDLE,
    W_DIV_SPD,
    W_INTEG,
    W_MUL_KI,
    W_DUTY,
    W_MUL_PWM,
    W_DIV_CMP,
    W_DONE
  } wheel_state_e;

  typedef struct packed {
    logic [11:0] target_heading;
    logic [11:0] current_heading;
    logic [31:0] period_left;
    logic [31:0] period_right;
    logic        new_target;
  } in_item_t;

  typedef struct packed {
    logic               motor_enable;
    logic               reverse_left;
    logic               reverse_right;
    logic [15:0]        compare_left;
    logic [15:0]        compare_right;
    logic signed [11:0] wrapped_error;
  } out_item_t;

  typedef struct packed {
    logic [15:0] ki_gain;
    logic [6:0]  duty_min;
    logic [6:0]  duty_max;
    logic [15:0] pwm_period;
  } wheel_cfg_t;

  typedef struct packed {
    logic        start;
    logic        clear;
    logic [6:0]  want;
    logic [31:0] period;
  } wheel_ctl_t;

  typedef struct packed {
    logic        done;
    logic [15:0] compare;
  } wheel_sts_t;

  // Register reset values
  localparam logic [15:0]        KP_GAIN_RST    = 16'd2621;
  localparam logic [15:0]        KI_GAIN_RST    = 16'd197;
  localparam logic signed [7:0]  BASE_SPEED_RST = 8'sd25;
  localparam logic [6:0]         DEADBAND_RST   = 7'd10;
  localparam logic [6:0]         LIMIT_RST      = 7'd50;
  localparam logic [6:0]         DUTY_MIN_RST   = 7'd10;
  localparam logic [6:0]         DUTY_MAX_RST   = 7'd90;
  localparam logic [15:0]        PWM_PERIOD_RST = 16'd960;
  localparam logic [15:0]        HELD_CMP_RST   = 16'd240;

  // Arithmetic constants
  localparam logic signed [12:0] HALF_TURN   = 13'sd1800;
  localparam logic signed [12:0] FULL_TURN   = 13'sd3600;
  localparam logic [22:0]        SPEED_NUM   = 23'd1500000;
  localparam logic [31:0]        PCT_DIV     = 32'd100;
  localparam logic [15:0]        DIV10_RECIP = 16'd52429;  // floor(x/10) = x*52429 >> 19

  // Step counts of the serial units
  localparam logic [4:0] DIV_STEPS = 5'd23;
  localparam logic [4:0] KP_STEPS  = 5'd11;
  localparam logic [4:0] KI_STEPS  = 5'd16;
  localparam logic [4:0] PWM_STEPS = 5'd7;

endpackage

>>> hdl/hspws_if.sv
// Interfaces: valid/ready channels carrying input and result items.
interface hspws_in_if import hspws_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface hspws_out_if import hspws_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> hdl/hspws_wheel.sv
// One wheel: serial speed divide, PI integrator, serial multiplies and PWM scaling.
module hspws_wheel import hspws_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  wheel_cfg_t cfg_i,
  input  wheel_ctl_t ctl_i,
  output wheel_sts_t sts_o
);

  wheel_state_e state_q, state_d;

  logic [4:0]         cnt_q;
  logic               last;
  logic signed [15:0] integ_q;
  logic [22:0]        num_q;
  logic [31:0]        rem_q;
  logic [22:0]        quo_q;
  logic [31:0]        acc_q;
  logic [15:0]        mul_q;
  logic               neg_q;

  // restoring divide step
  logic [31:0] den;
  logic [32:0] rem_ext;
  logic [32:0] rem_sub;
  logic        ge;

  // shift-add multiply step
  logic [15:0] mcand;
  logic [31:0] acc_step;

  // integrator and duty
  logic [22:0]        speed;
  logic signed [23:0] sum;
  logic signed [15:0] sat;
  logic [15:0]        sat_abs;
  logic signed [17:0] kterm;
  logic signed [17:0] duty;
  logic [6:0]         duty_clip;

  assign last = (cnt_q == 5'd1);

  always_comb begin
    den      = (state_q == W_DIV_CMP) ? PCT_DIV : ctl_i.period;
    rem_ext  = {rem_q, num_q[22]};
    rem_sub  = rem_ext - {1'b0, den};
    ge       = (rem_ext >= {1'b0, den});

    mcand    = (state_q == W_MUL_KI) ? cfg_i.ki_gain : cfg_i.pwm_period;
    acc_step = {acc_q[30:0], 1'b0} + (mul_q[15] ? {16'd0, mcand} : 32'd0);

    speed = (ctl_i.period == 32'd0) ? 23'd0 : quo_q;
    sum   = $signed({{8{integ_q[15]}}, integ_q}) + $signed({17'd0, ctl_i.want})
          - $signed({1'b0, speed});
    if (sum > 24'sd32767) begin
      sat = 16'sh7fff;
    end else if (sum < -24'sd32768) begin
      sat = 16'sh8000;
    end else begin
      sat = sum[15:0];
    end
    sat_abs = sat[15] ? (16'd0 - sat) : sat;

    kterm = neg_q ? -$signed({2'b00, acc_q[31:16]}) : $signed({2'b00, acc_q[31:16]});
    duty  = $signed({11'd0, ctl_i.want}) + kterm;
    if (duty < $signed({11'd0, cfg_i.duty_min})) begin
      duty_clip = cfg_i.duty_min;
    end else if (duty > $signed({11'd0, cfg_i.duty_max})) begin
      duty_clip = cfg_i.duty_max;
    end else begin
      duty_clip = duty[6:0];
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      W_IDLE:    if (ctl_i.start) state_d = W_DIV_SPD;
      W_DIV_SPD: if (last) state_d = W_INTEG;
      W_INTEG:   state_d = W_MUL_KI;
      W_MUL_KI:  if (last) state_d = W_DUTY;
      W_DUTY:    state_d = W_MUL_PWM;
      W_MUL_PWM: if (last) state_d = W_DIV_CMP;
      W_DIV_CMP: if (last) state_d = W_DONE;
      W_DONE:    state_d = W_IDLE;
      default:   state_d = W_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= W_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      integ_q <= '0;
    end else begin
      case (state_q)
        W_IDLE: begin
          if (ctl_i.clear) integ_q <= '0;
          if (ctl_i.start) cnt_q <= DIV_STEPS;
        end
        W_INTEG: cnt_q <= KI_STEPS;
        W_DUTY:  cnt_q <= PWM_STEPS;
        W_DIV_SPD, W_MUL_KI, W_DIV_CMP: cnt_q <= cnt_q - 5'd1;
        W_MUL_PWM: cnt_q <= last ? DIV_STEPS : (cnt_q - 5'd1);
        default: cnt_q <= cnt_q;
      endcase
      if (state_q == W_INTEG) integ_q <= sat;
    end
  end

  // datapath, no reset
  always_ff @(posedge clk_i) begin
    case (state_q)
      W_IDLE: begin
        num_q <= SPEED_NUM;
        rem_q <= '0;
        quo_q <= '0;
      end
      W_DIV_SPD, W_DIV_CMP: begin
        rem_q <= ge ? rem_sub[31:0] : rem_ext[31:0];
        quo_q <= {quo_q[21:0], ge};
        num_q <= {num_q[21:0], 1'b0};
      end
      W_INTEG: begin
        mul_q <= sat_abs;
        neg_q <= sat[15];
        acc_q <= '0;
      end
      W_MUL_KI: begin
        acc_q <= acc_step;
        mul_q <= {mul_q[14:0], 1'b0};
      end
      W_DUTY: begin
        mul_q <= {duty_clip, 9'd0};
        acc_q <= '0;
      end
      W_MUL_PWM: begin
        acc_q <= acc_step;
        mul_q <= {mul_q[14:0], 1'b0};
        if (last) begin
          num_q <= acc_step[22:0];
          rem_q <= '0;
          quo_q <= '0;
        end
      end
      default: begin
      end
    endcase
  end

  assign sts_o.done    = (state_q == W_DONE);
  assign sts_o.compare = (quo_q > 23'd65535) ? 16'hffff : quo_q[15:0];

endmodule

>>> hdl/heading_steer_pi_wheel_speed.sv
// Top level: heading error, steering offset, request shaping and two wheel PI loops.
// Sequence: S_ERR, S_KP, S_STEER, S_SHAPE, S_WHEEL, S_DONE; S_WHEEL is skipped when both
//   wheel requests are zero (motors off, no PI update), and S_DONE waits for a free output.
// One item at a time: no new input until the result is registered; the wheel work is the
//   two 23-step bit-serial divides and the 16- and 7-step shift-add multiplies per wheel.
// Reset: asynchronous, active low; registers to their defaults, integrators to zero,
//   held compares to 240, held directions forward, no result pending.
module heading_steer_pi_wheel_speed import hspws_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  hspws_in_if.sink    in_i,
  hspws_out_if.source out_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [15:0]       kp_gain_q;
  logic [15:0]       ki_gain_q;
  logic signed [7:0] base_speed_q;
  logic [6:0]        deadband_q;
  logic [6:0]        limit_q;
  logic [6:0]        duty_min_q;
  logic [6:0]        duty_max_q;
  logic [15:0]       pwm_period_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_gain_q    <= KP_GAIN_RST;
      ki_gain_q    <= KI_GAIN_RST;
      base_speed_q <= BASE_SPEED_RST;
      deadband_q   <= DEADBAND_RST;
      limit_q      <= LIMIT_RST;
      duty_min_q   <= DUTY_MIN_RST;
      duty_max_q   <= DUTY_MAX_RST;
      pwm_period_q <= PWM_PERIOD_RST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_KP_GAIN:     kp_gain_q    <= cfg_data_i;
        REG_KI_GAIN:     ki_gain_q    <= cfg_data_i;
        REG_BASE_SPEED:  base_speed_q <= cfg_data_i[7:0];
        REG_DEADBAND:    deadband_q   <= cfg_data_i[6:0];
        REG_SPEED_LIMIT: limit_q      <= cfg_data_i[6:0];
        REG_DUTY_MIN:    duty_min_q   <= cfg_data_i[6:0];
        REG_DUTY_MAX:    duty_max_q   <= cfg_data_i[6:0];
        REG_PWM_PERIOD:  pwm_period_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  top_state_e state_q, state_d;

  logic in_xfer;
  logic out_free;
  logic wheel_go;

  in_item_t  item_q;           // captured input item, stable for the whole tick
  out_item_t out_q;
  logic      out_valid_q;

  logic signed [11:0] err_q;   // wrapped heading error
  logic               err_neg_q;
  logic [10:0]        kp_mul_q;   // |error| bits, consumed MSB first
  logic [26:0]        kp_acc_q;   // |error| * kp_gain
  logic [4:0]         cnt_q;
  logic signed [8:0]  steer_q;
  logic               enable_q;

  // shaped requests, sign and magnitude
  logic       neg_l_q, neg_r_q;
  logic [6:0] mag_l_q, mag_r_q;

  // held outputs
  logic        rev_l_q, rev_r_q;
  logic [15:0] cmp_l_q, cmp_r_q;

  wheel_cfg_t wcfg;
  wheel_ctl_t ctl_l, ctl_r;
  wheel_sts_t sts_l, sts_r;

  // Heading error, wrapped once
  logic signed [12:0] diff;
  logic signed [12:0] wrapped;
  logic [11:0]        err_abs;

  // Steering offset: trunc(|err|*kp >> 16) / 10 via reciprocal
  logic [26:0] kp_step;
  logic [26:0] div10_prod;
  logic [7:0]  steer_mag;

  // Request shaping
  logic signed [9:0] s_left, s_right;
  logic              nl, nr;
  logic [6:0]        ml, mr;

  // Deadband first, then the limit; a limit of zero yields a plain zero.
  function automatic logic [7:0] shape(input logic signed [9:0] s,
                                       input logic [6:0] deadband,
                                       input logic [6:0] limit);
    logic [9:0] mag;
    logic [7:0] res;
    mag = s[9] ? (10'd0 - s) : s;
    if (mag < {3'd0, deadband}) begin
      res = 8'd0;
    end else if (mag > {3'd0, limit}) begin
      res = {s[9] & (limit != 7'd0), limit};
    end else begin
      res = {s[9], mag[6:0]};
    end
    return res;
  endfunction

  assign in_xfer  = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;

  always_comb begin
    diff = $signed({1'b0, item_q.target_heading}) - $signed({1'b0, item_q.current_heading});
    if (diff > HALF_TURN) begin
      wrapped = diff - FULL_TURN;
    end else if (diff < -HALF_TURN) begin
      wrapped = diff + FULL_TURN;
    end else begin
      wrapped = diff;
    end
    err_abs = wrapped[12] ? 12'(13'sd0 - wrapped) : wrapped[11:0];

    kp_step    = {kp_acc_q[25:0], 1'b0} + (kp_mul_q[10] ? {11'd0, kp_gain_q} : 27'd0);
    div10_prod = kp_acc_q[26:16] * DIV10_RECIP;
    steer_mag  = div10_prod[26:19];

    s_left  = $signed({{2{base_speed_q[7]}}, base_speed_q}) - $signed({steer_q[8], steer_q});
    s_right = $signed({{2{base_speed_q[7]}}, base_speed_q}) + $signed({steer_q[8], steer_q});
    {nl, ml} = shape(s_left, deadband_q, limit_q);
    {nr, mr} = shape(s_right, deadband_q, limit_q);
  end

  // Next state and wheel start
  always_comb begin
    state_d  = state_q;
    wheel_go = 1'b0;
    case (state_q)
      S_IDLE:  if (in_xfer) state_d = S_ERR;
      S_ERR:   state_d = S_KP;
      S_KP:    if (cnt_q == 5'd1) state_d = S_STEER;
      S_STEER: state_d = S_SHAPE;
      S_SHAPE: begin
        if (ml != 7'd0 || mr != 7'd0) begin
          wheel_go = 1'b1;
          state_d  = S_WHEEL;
        end else begin
          state_d = S_DONE;
        end
      end
      S_WHEEL: if (sts_l.done && sts_r.done) state_d = S_DONE;
      S_DONE:  if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  assign in_i.ready = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Control and held state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      enable_q    <= 1'b0;
      rev_l_q     <= 1'b0;
      rev_r_q     <= 1'b0;
      cmp_l_q     <= HELD_CMP_RST;
      cmp_r_q     <= HELD_CMP_RST;
    end else begin
      // a new result may replace one that transfers in the same cycle
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_ERR:   cnt_q <= KP_STEPS;
        S_KP:    cnt_q <= cnt_q - 5'd1;
        S_SHAPE: enable_q <= wheel_go;
        S_WHEEL: begin
          if (sts_l.done && sts_r.done) begin
            rev_l_q <= neg_l_q;
            rev_r_q <= neg_r_q;
            cmp_l_q <= sts_l.compare;
            cmp_r_q <= sts_r.compare;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    if (in_xfer) item_q <= in_i.data;
    case (state_q)
      S_ERR: begin
        err_q     <= wrapped[11:0];
        err_neg_q <= wrapped[12];
        kp_mul_q  <= err_abs[10:0];
        kp_acc_q  <= '0;
      end
      S_KP: begin
        kp_acc_q <= kp_step;
        kp_mul_q <= {kp_mul_q[9:0], 1'b0};
      end
      S_STEER: steer_q <= err_neg_q ? -$signed({1'b0, steer_mag}) : $signed({1'b0, steer_mag});
      S_SHAPE: begin
        neg_l_q <= nl;
        mag_l_q <= ml;
        neg_r_q <= nr;
        mag_r_q <= mr;
      end
      S_DONE: begin
        if (out_free) begin
          out_q.motor_enable  <= enable_q;
          out_q.reverse_left  <= rev_l_q;
          out_q.reverse_right <= rev_r_q;
          out_q.compare_left  <= cmp_l_q;
          out_q.compare_right <= cmp_r_q;
          out_q.wrapped_error <= err_q;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  // ---------------------------------------------------------------------------
  // Wheel loops: both run the same schedule and finish together
  // ---------------------------------------------------------------------------
  assign wcfg.ki_gain    = ki_gain_q;
  assign wcfg.duty_min   = duty_min_q;
  assign wcfg.duty_max   = duty_max_q;
  assign wcfg.pwm_period = pwm_period_q;

  // integrator clear rides on the input transfer, ahead of any PI update
  assign ctl_l.start  = wheel_go;
  assign ctl_l.clear  = in_xfer && in_i.data.new_target;
  assign ctl_l.want   = (state_q == S_SHAPE) ? ml : mag_l_q;
  assign ctl_l.period = item_q.period_left;

  assign ctl_r.start  = wheel_go;
  assign ctl_r.clear  = in_xfer && in_i.data.new_target;
  assign ctl_r.want   = (state_q == S_SHAPE) ? mr : mag_r_q;
  assign ctl_r.period = item_q.period_right;

  hspws_wheel u_wheel_left (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (wcfg),
    .ctl_i  (ctl_l),
    .sts_o  (sts_l)
  );

  hspws_wheel u_wheel_right (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (wcfg),
    .ctl_i  (ctl_r),
    .sts_o  (sts_r)
  );

endmodule
